// File: rtl/core/text_integer_reader_defines.svh
// Assertion macros used by the checker file of the text integer reader.
`ifndef TEXT_INTEGER_READER_DEFINES_SVH
`define TEXT_INTEGER_READER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define TIR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define TIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/tir_pkg.sv
package tir_pkg;

   localparam int unsigned CH_W        = 8;
   localparam int unsigned VALUE_W     = 64;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned RADIX_W     = 5;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned REQ_DATA_W  = 8;
   localparam int unsigned RSP_DATA_W  = 72;
   localparam int unsigned PROD_W      = VALUE_W + RADIX_W;

   localparam logic [CSR_INDEX_W-1:0] REG_RADIX       = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIGNED_MODE = 4'd1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_DIGIT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

   localparam logic [RADIX_W-1:0] RADIX_RESET  = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN    = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX    = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_SIGNED = 5'd10;
   localparam logic [DIGIT_W-1:0] LETTER_BASE  = 4'd10;

   localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CH_W-1:0] CH_CR      = 8'h0D;
   localparam logic [CH_W-1:0] CH_LF      = 8'h0A;
   localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_F = 8'h46;
   localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_F = 8'h66;

   localparam logic [VALUE_W-1:0] LIMIT_UNSIGNED   = {VALUE_W{1'b1}};
   localparam logic [VALUE_W-1:0] LIMIT_SIGNED_POS = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] LIMIT_SIGNED_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CLS_SPACE,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_OTHER
   } class_type;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_MINUS,
      PH_DIGIT,
      PH_DROP
   } phase_type;

   typedef struct packed {
      class_type            cls;
      logic [DIGIT_W-1:0]   digit;
      logic                 eos;
   } entry_type;

   typedef struct packed {
      logic [RADIX_W-1:0]   radix;
      logic                 signed_mode;
   } cfg_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   value;
      logic [STATUS_W-1:0]  status;
      logic                 last;
   } result_type;

endpackage

// File: rtl/core/tir_front.sv
module tir_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tir_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tir_pkg::RADIX_W-1:0]         csr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tir_pkg::REQ_DATA_W-1:0]      req_tdata,   // [7:0] ch
   input  logic                                req_tlast,
   output logic                                push_valid,
   input  logic                                push_ready,
   output tir_pkg::entry_type                  push_entry,
   output tir_pkg::cfg_type                    cfg
);

   logic [tir_pkg::RADIX_W-1:0] radix_ff;
   logic [tir_pkg::RADIX_W-1:0] radix_in;
   logic                        signed_mode_ff;
   logic                        signed_mode_in;
   logic [tir_pkg::CH_W-1:0]    ch;
   logic [tir_pkg::CH_W-1:0]    ch_offset;
   logic [tir_pkg::DIGIT_W-1:0] raw_digit;
   logic                        raw_ok;
   logic                        digit_ok;

   assign csr_ready = 1'b1;

   always_comb begin
      radix_in       = radix_ff;
      signed_mode_in = signed_mode_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tir_pkg::REG_RADIX: begin
               radix_in = csr_data;
            end
            tir_pkg::REG_SIGNED_MODE: begin
               signed_mode_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= tir_pkg::RADIX_RESET;
         signed_mode_ff <= 1'b0;
      end else begin
         radix_ff       <= radix_in;
         signed_mode_ff <= signed_mode_in;
      end
   end

   always_comb begin
      cfg.signed_mode = signed_mode_ff;
      if (signed_mode_ff) begin
         cfg.radix = tir_pkg::RADIX_SIGNED;
      end else if (radix_ff inside {[tir_pkg::RADIX_MIN:tir_pkg::RADIX_MAX]}) begin
         cfg.radix = radix_ff;
      end else begin
         cfg.radix = '0;
      end
   end

   assign ch = req_tdata[tir_pkg::CH_W-1:0];

   always_comb begin
      raw_ok    = 1'b1;
      ch_offset = '0;
      if (ch inside {[tir_pkg::CH_ZERO:tir_pkg::CH_NINE]}) begin
         ch_offset = ch - tir_pkg::CH_ZERO;
      end else if (ch inside {[tir_pkg::CH_UPPER_A:tir_pkg::CH_UPPER_F]}) begin
         ch_offset = ch - tir_pkg::CH_UPPER_A + {4'd0, tir_pkg::LETTER_BASE};
      end else if (ch inside {[tir_pkg::CH_LOWER_A:tir_pkg::CH_LOWER_F]}) begin
         ch_offset = ch - tir_pkg::CH_LOWER_A + {4'd0, tir_pkg::LETTER_BASE};
      end else begin
         raw_ok = 1'b0;
      end
      raw_digit = ch_offset[tir_pkg::DIGIT_W-1:0];
      digit_ok  = raw_ok && ({1'b0, raw_digit} < cfg.radix);
   end

   always_comb begin
      push_entry.digit = raw_digit;
      push_entry.eos   = req_tlast;
      if (ch inside {tir_pkg::CH_SPACE, tir_pkg::CH_TAB, tir_pkg::CH_CR, tir_pkg::CH_LF}) begin
         push_entry.cls = tir_pkg::CLS_SPACE;
      end else if (signed_mode_ff && ch == tir_pkg::CH_MINUS) begin
         push_entry.cls = tir_pkg::CLS_MINUS;
      end else if (digit_ok) begin
         push_entry.cls = tir_pkg::CLS_DIGIT;
      end else begin
         push_entry.cls = tir_pkg::CLS_OTHER;
      end
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

// File: rtl/core/tir_queue.sv
module tir_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tir_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tir_pkg::entry_type pop_entry
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tir_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               push;
   logic               pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/tir_back.sv
module tir_back (
   input  logic                              clock,
   input  logic                              reset,
   input  tir_pkg::cfg_type                  cfg,
   input  logic                              head_valid,
   output logic                              head_ready,
   input  tir_pkg::entry_type                head,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tir_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [63:0] value, [65:64] status
   output logic                              rsp_tlast
);

   localparam int unsigned VW = tir_pkg::VALUE_W;
   localparam int unsigned PW = tir_pkg::PROD_W;

   tir_pkg::phase_type    phase_ff;
   tir_pkg::phase_type    phase_in;
   tir_pkg::phase_type    step_phase;
   logic [VW-1:0]         acc_ff;
   logic [VW-1:0]         acc_in;
   logic [VW-1:0]         step_acc;
   logic                  neg_ff;
   logic                  neg_in;
   logic                  step_neg;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   tir_pkg::result_type   out_res_ff;
   tir_pkg::result_type   out_res_in;
   logic                  hold_valid_ff;
   logic                  hold_valid_in;
   tir_pkg::result_type   hold_res_ff;
   tir_pkg::result_type   hold_res_in;

   tir_pkg::phase_type    begin_phase;
   logic [VW-1:0]         begin_acc;
   logic                  begin_neg;
   logic                  begin_res_valid;
   tir_pkg::result_type   begin_res;

   logic                  r0_valid;
   tir_pkg::result_type   r0;
   logic                  r1_valid;
   tir_pkg::result_type   r1;

   logic [VW-1:0]         digit_ext;
   logic [PW-1:0]         step_prod;
   logic [PW:0]           step_sum;
   logic [VW-1:0]         step_limit;
   logic                  step_ovf;
   logic [VW-1:0]         step_value;
   logic                  signed_neg;
   logic [VW-1:0]         close_value;
   logic [VW-1:0]         step_close;
   logic [VW-1:0]         minus_close;
   logic                  is_digit;
   logic                  out_free;
   logic                  pop;

   assign digit_ext  = {{(VW-tir_pkg::DIGIT_W){1'b0}}, head.digit};
   assign is_digit   = (head.cls == tir_pkg::CLS_DIGIT);
   assign signed_neg = cfg.signed_mode && neg_ff;

   // Accumulate step: one small-radix multiply, then add the digit and compare.
   assign step_prod  = {{tir_pkg::RADIX_W{1'b0}}, acc_ff} * {{VW{1'b0}}, cfg.radix};
   assign step_sum   = {1'b0, step_prod} + {{(PW+1-tir_pkg::DIGIT_W){1'b0}}, head.digit};
   assign step_value = step_sum[VW-1:0];

   always_comb begin
      if (!cfg.signed_mode) begin
         step_limit = tir_pkg::LIMIT_UNSIGNED;
      end else if (neg_ff) begin
         step_limit = tir_pkg::LIMIT_SIGNED_NEG;
      end else begin
         step_limit = tir_pkg::LIMIT_SIGNED_POS;
      end
      step_ovf = step_sum > {{(PW+1-VW){1'b0}}, step_limit};
   end

   assign close_value = signed_neg ? -acc_ff : acc_ff;
   assign step_close  = signed_neg ? -step_value : step_value;
   assign minus_close = signed_neg ? -digit_ext : digit_ext;

   always_comb begin
      begin_phase      = tir_pkg::PH_SKIP;
      begin_acc        = '0;
      begin_neg        = 1'b0;
      begin_res_valid  = 1'b0;
      begin_res.value  = '0;
      begin_res.status = tir_pkg::ST_OK;
      begin_res.last   = 1'b1;
      case (head.cls)
         tir_pkg::CLS_SPACE: begin
         end
         tir_pkg::CLS_MINUS: begin
            if (head.eos) begin
               begin_res_valid  = 1'b1;
               begin_res.status = tir_pkg::ST_NO_DIGIT;
            end else begin
               begin_phase = tir_pkg::PH_MINUS;
               begin_neg   = 1'b1;
            end
         end
         tir_pkg::CLS_DIGIT: begin
            if (head.eos) begin
               begin_res_valid = 1'b1;
               begin_res.value = digit_ext;
            end else begin
               begin_phase = tir_pkg::PH_DIGIT;
               begin_acc   = digit_ext;
            end
         end
         default: begin
            begin_res_valid  = 1'b1;
            begin_res.status = tir_pkg::ST_NO_DIGIT;
            begin_phase      = head.eos ? tir_pkg::PH_SKIP : tir_pkg::PH_DROP;
         end
      endcase
   end

   always_comb begin
      step_phase = phase_ff;
      step_acc   = acc_ff;
      step_neg   = neg_ff;
      case (phase_ff)
         tir_pkg::PH_SKIP: begin
            step_phase = begin_phase;
            step_acc   = begin_acc;
            step_neg   = begin_neg;
         end
         tir_pkg::PH_MINUS: begin
            if (is_digit && !head.eos) begin
               step_phase = tir_pkg::PH_DIGIT;
               step_acc   = digit_ext;
            end else begin
               step_phase = (is_digit || head.eos) ? tir_pkg::PH_SKIP : tir_pkg::PH_DROP;
               step_acc   = '0;
               step_neg   = 1'b0;
            end
         end
         tir_pkg::PH_DIGIT: begin
            if (!is_digit) begin
               step_phase = begin_phase;
               step_acc   = begin_acc;
               step_neg   = begin_neg;
            end else if (step_ovf || head.eos) begin
               step_phase = (head.eos) ? tir_pkg::PH_SKIP : tir_pkg::PH_DROP;
               step_acc   = '0;
               step_neg   = 1'b0;
            end else begin
               step_acc = step_value;
            end
         end
         tir_pkg::PH_DROP: begin
            if (head.eos) begin
               step_phase = tir_pkg::PH_SKIP;
            end
         end
         default: begin
            step_phase = tir_pkg::PH_SKIP;
         end
      endcase
   end

   always_comb begin
      r0_valid  = 1'b0;
      r0.value  = '0;
      r0.status = tir_pkg::ST_OK;
      r0.last   = 1'b1;
      r1_valid  = 1'b0;
      r1        = begin_res;
      case (phase_ff)
         tir_pkg::PH_SKIP: begin
            r0_valid = begin_res_valid;
            r0       = begin_res;
         end
         tir_pkg::PH_MINUS: begin
            if (!is_digit) begin
               r0_valid  = 1'b1;
               r0.status = tir_pkg::ST_NO_DIGIT;
            end else if (head.eos) begin
               r0_valid = 1'b1;
               r0.value = minus_close;
            end
         end
         tir_pkg::PH_DIGIT: begin
            if (!is_digit) begin
               r0_valid = 1'b1;
               r0.value = close_value;
               r0.last  = !begin_res_valid;
               r1_valid = begin_res_valid;
            end else if (step_ovf) begin
               r0_valid  = 1'b1;
               r0.status = tir_pkg::ST_OVERFLOW;
            end else if (head.eos) begin
               r0_valid = 1'b1;
               r0.value = step_close;
            end
         end
         default: begin
         end
      endcase
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign head_ready = !hold_valid_ff && (!r0_valid || out_free);
   assign pop        = head_valid && head_ready;

   always_comb begin
      phase_in      = pop ? step_phase : phase_ff;
      acc_in        = pop ? step_acc : acc_ff;
      neg_in        = pop ? step_neg : neg_ff;
      out_valid_in  = out_valid_ff;
      out_res_in    = out_res_ff;
      hold_valid_in = hold_valid_ff;
      hold_res_in   = hold_res_ff;
      if (pop && r0_valid) begin
         out_valid_in = 1'b1;
         out_res_in   = r0;
      end else if (hold_valid_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_res_in    = hold_res_ff;
         hold_valid_in = 1'b0;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
      if (pop && r1_valid) begin
         hold_valid_in = 1'b1;
         hold_res_in   = r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tir_pkg::PH_SKIP;
         acc_ff        <= '0;
         neg_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         neg_ff        <= neg_in;
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      hold_res_ff <= hold_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_res_ff.last;
   assign rsp_tdata  = {{(tir_pkg::RSP_DATA_W-VW-tir_pkg::STATUS_W){1'b0}},
                        out_res_ff.status, out_res_ff.value};

endmodule

// File: rtl/core/text_integer_reader.sv
// Text integer reader: turns a stream of text bytes into 64-bit integers.
// req_* carries one byte per transfer in req_tdata[7:0]; req_tlast marks the
// last byte of a source. rsp_* carries one result per transfer: value in
// rsp_tdata[63:0], status in rsp_tdata[65:64] (0 ok, 1 no digit, 2 overflow),
// and rsp_tlast set on the final result that a byte causes.
// csr_* writes register 0 (radix, 2 to 16) or register 1 (signed mode, which
// allows a leading minus and works in base ten); write only while idle.
// A result passes the byte queue and the output register. One byte is taken
// per cycle while the queue has room. A byte that ends a number and opens a
// bad token yields two results and stalls the back end while the second waits.
// Reset sets radix ten, unsigned mode, and empties the byte queue and the
// output register. When the receiver stalls, results wait in the output
// register, bytes collect in a queue of QUEUE_DEPTH entries, and req_tready
// falls once that queue is full.
module text_integer_reader #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tir_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tir_pkg::RADIX_W-1:0]        csr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tir_pkg::REQ_DATA_W-1:0]     req_tdata,   // [7:0] ch
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tir_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [63:0] value, [65:64] status
   output logic                               rsp_tlast
);

   tir_pkg::cfg_type   cfg;
   logic               push_valid;
   logic               push_ready;
   tir_pkg::entry_type push_entry;
   logic               head_valid;
   logic               head_ready;
   tir_pkg::entry_type head;

   tir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .cfg        (cfg)
   );

   tir_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_entry  (head)
   );

   tir_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_ready (head_ready),
      .head       (head),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/core/text_integer_reader_checker.sv
`include "text_integer_reader_defines.svh"

module text_integer_reader_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tir_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast
);

   logic [tir_pkg::STATUS_W-1:0] status;
   logic [tir_pkg::VALUE_W-1:0]  value;

   assign value  = rsp_tdata[tir_pkg::VALUE_W-1:0];
   assign status = rsp_tdata[tir_pkg::VALUE_W +: tir_pkg::STATUS_W];

   `TIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   `TIR_ASSERT_IMPLY(a_status_code, clock, reset, rsp_tvalid, status == tir_pkg::ST_OK || status == tir_pkg::ST_NO_DIGIT || status == tir_pkg::ST_OVERFLOW, "unknown status code")

   `TIR_ASSERT_IMPLY(a_error_zero, clock, reset, rsp_tvalid && status != tir_pkg::ST_OK, value == '0, "error result carries a value")

   `TIR_ASSERT_IMPLY(a_first_of_two_ok, clock, reset, rsp_tvalid && !rsp_tlast, status == tir_pkg::ST_OK, "first of two results is not a closed number")

endmodule

bind text_integer_reader text_integer_reader_checker u_checker (.*);
